// File: rtl/bfsp_pkg.sv
// Package with shared constants, types and helpers of the shortest path engine.
package bfsp_pkg;

	localparam int MAX_VERTICES_DEF = 64;
	localparam int MAX_EDGES_DEF = 256;
	localparam int WEIGHT_WIDTH_DEF = 16;

	localparam int VIDX_W = 6;
	localparam int DIST_W = 22;
	localparam int VCNT_W = 7;
	localparam int ECNT_W = 9;
	localparam int CFG_W = 9;

	localparam logic signed [DIST_W-1:0] DIST_MIN = -22'sd2097152;
	localparam logic signed [DIST_W-1:0] DIST_MAX = 22'sd2097151;

	// Register indexes of the configuration port.
	localparam logic CFG_VERTEX_COUNT = 1'b0;
	localparam logic CFG_EDGE_COUNT = 1'b1;

	// Result status codes.
	localparam logic [1:0] ST_DIST = 2'd0;
	localparam logic [1:0] ST_NEGCYC = 2'd1;
	localparam logic [1:0] ST_BADSRC = 2'd2;

	// Commands from the controller to the datapath.
	typedef struct packed {
		logic clr;        // clear reachable bits, mark source
		logic rd_dist;    // read distances of the edge endpoints
		logic relax;      // evaluate the edge and write back when in pass mode
		logic check;      // evaluate without writing, flag a negative cycle
		logic rd_out;     // read the distance of the output vertex
	} bfsp_cmd_t;

	// Status from the datapath.
	typedef struct packed {
		logic neg_found;
	} bfsp_stat_t;

endpackage

// File: rtl/bfsp_ram.sv
// Generic single-port-write, single-port-read RAM with registered read data.
module bfsp_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 16
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	// Write port and registered read port.
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

// File: rtl/bfsp_datapath.sv
// Datapath: edge store, distance store, reachable bits and relaxation unit.
module bfsp_datapath #(
	parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES = bfsp_pkg::MAX_EDGES_DEF,
	parameter int WEIGHT_WIDTH = bfsp_pkg::WEIGHT_WIDTH_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            load_we,
	input  logic [$clog2(MAX_EDGES)-1:0]    load_addr,
	input  logic [bfsp_pkg::VIDX_W-1:0]     load_from,
	input  logic [bfsp_pkg::VIDX_W-1:0]     load_to,
	input  logic signed [WEIGHT_WIDTH-1:0]  load_weight,
	input  bfsp_pkg::bfsp_cmd_t             cmd,
	input  logic [$clog2(MAX_EDGES)-1:0]    edge_idx,
	input  logic [$clog2(MAX_VERTICES):0]   nv,
	input  logic [$clog2(MAX_VERTICES)-1:0] src,
	input  logic [$clog2(MAX_VERTICES)-1:0] out_idx,
	output bfsp_pkg::bfsp_stat_t            stat,
	output logic signed [bfsp_pkg::DIST_W-1:0] out_dist,
	output logic                            out_reach
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int EW = 2 * bfsp_pkg::VIDX_W + WEIGHT_WIDTH;
	localparam int SW = bfsp_pkg::DIST_W + 2;

	logic [EW-1:0] edge_rd;
	logic [bfsp_pkg::VIDX_W-1:0] e_from, e_to;
	logic signed [WEIGHT_WIDTH-1:0] e_w;
	logic [MAX_VERTICES-1:0] reach_q;
	logic signed [bfsp_pkg::DIST_W-1:0] du, dv;
	logic [bfsp_pkg::VIDX_W-1:0] from_s2, to_s2;
	logic signed [WEIGHT_WIDTH-1:0] w_s2;
	logic signed [SW-1:0] cand;
	logic signed [bfsp_pkg::DIST_W-1:0] cand_sat;
	logic ok, better, dwe;
	logic [VW-1:0] dist_raddr_a;
	logic [VW-1:0] dist_waddr;
	logic signed [bfsp_pkg::DIST_W-1:0] dist_wdata;
	logic neg_q;

	bfsp_ram #(.WIDTH(EW), .DEPTH(MAX_EDGES)) u_edges (
		.clk(clk), .we(load_we), .waddr(load_addr),
		.wdata({load_weight, load_to, load_from}),
		.raddr(edge_idx), .rdata(edge_rd)
	);

	assign e_from = edge_rd[bfsp_pkg::VIDX_W-1:0];
	assign e_to = edge_rd[2*bfsp_pkg::VIDX_W-1:bfsp_pkg::VIDX_W];
	assign e_w = edge_rd[EW-1:2*bfsp_pkg::VIDX_W];

	// Two distance copies give two read ports; both are written together.
	assign dist_raddr_a = cmd.rd_out ? out_idx : VW'(e_from);

	// A clear puts distance zero at the source; a relaxation writes the destination.
	assign dist_waddr = cmd.clr ? src : VW'(to_s2);
	assign dist_wdata = cmd.clr ? '0 : cand_sat;

	bfsp_ram #(.WIDTH(bfsp_pkg::DIST_W), .DEPTH(MAX_VERTICES)) u_dist_a (
		.clk(clk), .we(dwe), .waddr(dist_waddr), .wdata(dist_wdata),
		.raddr(dist_raddr_a), .rdata(du)
	);
	bfsp_ram #(.WIDTH(bfsp_pkg::DIST_W), .DEPTH(MAX_VERTICES)) u_dist_b (
		.clk(clk), .we(dwe), .waddr(dist_waddr), .wdata(dist_wdata),
		.raddr(VW'(e_to)), .rdata(dv)
	);

	// Hold the edge beside the distance read.
	always_ff @(posedge clk) begin
		if (cmd.rd_dist) begin
			from_s2 <= e_from;
			to_s2 <= e_to;
			w_s2 <= e_w;
		end
	end

	// Relaxation test against the stored destination distance.
	always_comb begin
		ok = ({1'b0, from_s2} < nv) && ({1'b0, to_s2} < nv) && reach_q[VW'(from_s2)];
		cand = SW'(du) + SW'(w_s2);
		better = !reach_q[VW'(to_s2)] || (cand < SW'(dv));
		if (cand < SW'(bfsp_pkg::DIST_MIN)) begin
			cand_sat = bfsp_pkg::DIST_MIN;
		end else if (cand > SW'(bfsp_pkg::DIST_MAX)) begin
			cand_sat = bfsp_pkg::DIST_MAX;
		end else begin
			cand_sat = cand[bfsp_pkg::DIST_W-1:0];
		end
		dwe = (cmd.relax && ok && better) || cmd.clr;
	end

	// Reachable bits and the negative cycle flag; a clear leaves only the source set.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			reach_q <= '0;
			neg_q <= 1'b0;
		end else if (cmd.clr) begin
			reach_q <= MAX_VERTICES'(1) << src;
			neg_q <= 1'b0;
		end else begin
			if (cmd.relax && ok && better) begin
				reach_q[VW'(to_s2)] <= 1'b1;
			end
			if (cmd.check && ok && better) begin
				neg_q <= 1'b1;
			end
		end
	end

	assign stat.neg_found = neg_q;
	assign out_dist = du;
	assign out_reach = reach_q[out_idx];

endmodule

// File: rtl/bfsp_ctrl.sv
// Controller: run sequencing, edge and pass counters, output handshake.
module bfsp_ctrl #(
	parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES = bfsp_pkg::MAX_EDGES_DEF
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            run_req,
	output logic                            busy,
	input  logic [$clog2(MAX_VERTICES):0]   nv,
	input  logic [$clog2(MAX_EDGES):0]      ne,
	input  logic [bfsp_pkg::VIDX_W-1:0]     start,
	output logic [$clog2(MAX_VERTICES)-1:0] src,
	output bfsp_pkg::bfsp_cmd_t             cmd,
	output logic [$clog2(MAX_EDGES)-1:0]    edge_idx,
	output logic [$clog2(MAX_VERTICES)-1:0] out_idx,
	input  bfsp_pkg::bfsp_stat_t            stat,
	input  logic signed [bfsp_pkg::DIST_W-1:0] dp_dist,
	input  logic                            dp_reach,
	output logic                            o_valid,
	input  logic                            o_ready,
	output logic [1:0]                      o_status,
	output logic [bfsp_pkg::VIDX_W-1:0]     o_vidx,
	output logic signed [bfsp_pkg::DIST_W-1:0] o_dist,
	output logic                            o_reach,
	output logic                            o_last
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int EW = $clog2(MAX_EDGES);

	typedef enum logic [2:0] {
		S_IDLE, S_CLR, S_EDGE, S_DRAIN, S_OREAD, S_OWAIT, S_OSEND
	} state_t;

	state_t state_q;
	logic [EW:0] ecnt_q;
	logic [VW:0] pass_q;
	logic [1:0] pipe_q; // relax stage valid: [0] dist read, [1] evaluate
	logic chk_q;
	logic [VW-1:0] src_q;

	assign src = src_q;
	assign busy = (state_q != S_IDLE);
	assign edge_idx = ecnt_q[EW-1:0];

	// Edge read, distance read and evaluation are registered steps in that order; the next
	// edge starts only after the write so that its reads see the new distance.
	always_comb begin
		cmd = '0;
		cmd.clr = (state_q == S_CLR);
		cmd.rd_dist = pipe_q[0];
		cmd.relax = pipe_q[1] && !chk_q;
		cmd.check = pipe_q[1] && chk_q;
		cmd.rd_out = (state_q == S_OREAD);
	end

	// Sequencer with registered outputs.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ecnt_q <= '0;
			pass_q <= '0;
			pipe_q <= '0;
			chk_q <= 1'b0;
			src_q <= '0;
			out_idx <= '0;
			o_valid <= 1'b0;
			o_status <= bfsp_pkg::ST_DIST;
			o_vidx <= '0;
			o_dist <= '0;
			o_reach <= 1'b0;
			o_last <= 1'b0;
		end else begin
			// An edge enters the relax pipe when the edge state reads a valid index.
			pipe_q <= {pipe_q[0], (state_q == S_EDGE) && (ecnt_q != ne)};
			case (state_q)
				S_IDLE: begin
					if (run_req) begin
						src_q <= VW'(start);
						if ({1'b0, start} >= (bfsp_pkg::VIDX_W+1)'(nv)) begin
							o_valid <= 1'b1;
							o_status <= bfsp_pkg::ST_BADSRC;
							o_vidx <= '0;
							o_dist <= '0;
							o_reach <= 1'b0;
							o_last <= 1'b1;
							state_q <= S_OSEND;
						end else begin
							state_q <= S_CLR;
						end
					end
				end
				S_CLR: begin
					pass_q <= (VW+1)'(1);
					chk_q <= (nv == (VW+1)'(1));
					ecnt_q <= '0;
					state_q <= S_EDGE;
				end
				S_EDGE: begin
					// An edge starts only after the previous one is written, keeping each write ahead of the next read.
					state_q <= S_DRAIN;
				end
				S_DRAIN: begin
					if (!pipe_q[0]) begin
						if (ecnt_q == ne) begin
							ecnt_q <= '0;
							if (chk_q) begin
								if (stat.neg_found) begin
									o_valid <= 1'b1;
									o_status <= bfsp_pkg::ST_NEGCYC;
									o_vidx <= '0;
									o_dist <= '0;
									o_reach <= 1'b0;
									o_last <= 1'b1;
									state_q <= S_OSEND;
								end else begin
									out_idx <= '0;
									state_q <= S_OREAD;
								end
							end else begin
								pass_q <= pass_q + 1'b1;
								chk_q <= (pass_q + 1'b1 == nv);
								state_q <= S_EDGE;
							end
						end else begin
							ecnt_q <= ecnt_q + 1'b1;
							state_q <= S_EDGE;
						end
					end
				end
				S_OREAD: begin
					state_q <= S_OWAIT;
				end
				S_OWAIT: begin
					o_valid <= 1'b1;
					o_status <= bfsp_pkg::ST_DIST;
					o_vidx <= bfsp_pkg::VIDX_W'(out_idx);
					o_dist <= dp_reach ? dp_dist : '0;
					o_reach <= dp_reach;
					o_last <= ({1'b0, out_idx} + 1'b1 == nv);
					state_q <= S_OSEND;
				end
				S_OSEND: begin
					if (o_ready) begin
						o_valid <= 1'b0;
						if (o_last) begin
							state_q <= S_IDLE;
						end else begin
							out_idx <= out_idx + 1'b1;
							state_q <= S_OREAD;
						end
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// A result is only offered while its send state holds.
	a_valid_state: assert property (@(posedge clk) disable iff (!arst_n)
		o_valid |-> state_q == S_OSEND) else $error("valid outside send");
	// Relaxation writes and check evaluations never coincide.
	a_cmd_excl: assert property (@(posedge clk) disable iff (!arst_n)
		!(cmd.relax && cmd.check)) else $error("relax and check together");
	// The edge counter never passes the edge count while a run walks edges.
	a_ecnt: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_EDGE) |-> ecnt_q <= ne) else $error("edge counter overrun");

endmodule

// File: rtl/bellman_ford_shortest_paths.sv
// Top level of the single-source shortest path engine over a stored edge list.
// Usage: the s_axis channel takes items. func=0 (tuser) loads one edge into the
// next free slot of the edge store (up to MAX_EDGES, then ignored) and gives no
// result. func=1 starts a run from start_vertex. s_axis_tready is low while a
// run is in progress. A run clears reachability, then makes vertex_count-1
// relaxation passes and one check pass; each edge goes through edge read,
// distance read, and evaluate and write back before the next edge starts,
// since the next edge's distance read depends on each write. Results leave on
// m_axis: one per vertex, or a single status beat for a bad source or a
// negative cycle; tlast marks the last beat. When the receiver stalls, the
// current beat holds.
// Reset clears the fill count, sets vertex_count to 1 and edge_count to 0;
// edge store contents stay undefined until loaded.
// Configuration writes (cfg_we, cfg_index, cfg_wdata) take effect at once; the user
// must make them only while idle, as the block itself does not enforce this.
module bellman_ford_shortest_paths #(
	parameter int MAX_VERTICES = bfsp_pkg::MAX_VERTICES_DEF,
	parameter int MAX_EDGES = bfsp_pkg::MAX_EDGES_DEF,
	parameter int WEIGHT_WIDTH = bfsp_pkg::WEIGHT_WIDTH_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        s_axis_tvalid,
	output logic        s_axis_tready,
	// tdata: edge_from[5:0], edge_to[11:6], edge_weight, start_vertex, zero fill
	input  logic [((2*bfsp_pkg::VIDX_W+WEIGHT_WIDTH+bfsp_pkg::VIDX_W+7)/8)*8-1:0] s_axis_tdata,
	// tuser: func
	input  logic        s_axis_tuser,
	output logic        m_axis_tvalid,
	input  logic        m_axis_tready,
	// tdata: status[1:0], vertex_index[7:2], path_length[29:8], reachable[30], zero
	output logic [31:0] m_axis_tdata,
	output logic        m_axis_tlast,
	input  logic        cfg_we,
	input  logic        cfg_index,
	input  logic [bfsp_pkg::CFG_W-1:0] cfg_wdata
);

	localparam int VW = $clog2(MAX_VERTICES);
	localparam int EW = $clog2(MAX_EDGES);
	localparam int VI = bfsp_pkg::VIDX_W;

	logic [bfsp_pkg::VCNT_W-1:0] vcnt_q;
	logic [bfsp_pkg::ECNT_W-1:0] ecnt_cfg_q;
	logic [EW:0] fill_q;
	logic [VW:0] nv;
	logic [EW:0] ne;
	logic busy, load_acc, run_acc;
	logic [VW-1:0] src, out_idx;
	logic [EW-1:0] edge_idx;
	bfsp_pkg::bfsp_cmd_t cmd;
	bfsp_pkg::bfsp_stat_t stat;
	logic signed [bfsp_pkg::DIST_W-1:0] dp_dist, o_dist;
	logic dp_reach, o_reach;
	logic [1:0] o_status;
	logic [VI-1:0] o_vidx;
	logic signed [WEIGHT_WIDTH-1:0] in_w;
	logic [VI-1:0] in_start;

	assign in_w = s_axis_tdata[2*VI+WEIGHT_WIDTH-1:2*VI];
	assign in_start = s_axis_tdata[3*VI+WEIGHT_WIDTH-1:2*VI+WEIGHT_WIDTH];

	assign s_axis_tready = !busy;
	assign load_acc = s_axis_tvalid && s_axis_tready && !s_axis_tuser;
	assign run_acc = s_axis_tvalid && s_axis_tready && s_axis_tuser;

	// Effective counts with zero and overflow saturation.
	always_comb begin
		if (vcnt_q == '0) begin
			nv = (VW+1)'(1);
		end else if (32'(vcnt_q) > MAX_VERTICES) begin
			nv = (VW+1)'(MAX_VERTICES);
		end else begin
			nv = (VW+1)'(vcnt_q);
		end
		if (32'(ecnt_cfg_q) > MAX_EDGES) begin
			ne = (EW+1)'(MAX_EDGES);
		end else begin
			ne = (EW+1)'(ecnt_cfg_q);
		end
	end

	// Configuration registers and the edge fill count.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			vcnt_q <= bfsp_pkg::VCNT_W'(1);
			ecnt_cfg_q <= '0;
			fill_q <= '0;
		end else begin
			if (cfg_we && cfg_index == bfsp_pkg::CFG_VERTEX_COUNT) begin
				vcnt_q <= cfg_wdata[bfsp_pkg::VCNT_W-1:0];
			end
			if (cfg_we && cfg_index == bfsp_pkg::CFG_EDGE_COUNT) begin
				ecnt_cfg_q <= cfg_wdata[bfsp_pkg::ECNT_W-1:0];
			end
			if (load_acc && 32'(fill_q) < MAX_EDGES) begin
				fill_q <= fill_q + 1'b1;
			end
		end
	end

	bfsp_datapath #(
		.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES), .WEIGHT_WIDTH(WEIGHT_WIDTH)
	) u_dp (
		.clk(clk), .arst_n(arst_n),
		.load_we(load_acc && 32'(fill_q) < MAX_EDGES),
		.load_addr(fill_q[EW-1:0]),
		.load_from(s_axis_tdata[VI-1:0]),
		.load_to(s_axis_tdata[2*VI-1:VI]),
		.load_weight(in_w),
		.cmd(cmd), .edge_idx(edge_idx), .nv(nv), .src(src), .out_idx(out_idx),
		.stat(stat), .out_dist(dp_dist), .out_reach(dp_reach)
	);

	bfsp_ctrl #(.MAX_VERTICES(MAX_VERTICES), .MAX_EDGES(MAX_EDGES)) u_ctrl (
		.clk(clk), .arst_n(arst_n), .run_req(run_acc), .busy(busy),
		.nv(nv), .ne(ne), .start(in_start), .src(src), .cmd(cmd),
		.edge_idx(edge_idx), .out_idx(out_idx), .stat(stat),
		.dp_dist(dp_dist), .dp_reach(dp_reach),
		.o_valid(m_axis_tvalid), .o_ready(m_axis_tready),
		.o_status(o_status), .o_vidx(o_vidx), .o_dist(o_dist),
		.o_reach(o_reach), .o_last(m_axis_tlast)
	);

	assign m_axis_tdata = {1'b0, o_reach, o_dist, o_vidx, o_status};

endmodule

// File: tb/sv/testbench.sv
// Self-checking testbench for the shortest path engine.
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	localparam int VI_W = bfsp_pkg::VIDX_W;
	localparam int LEN_W = bfsp_pkg::DIST_W;
	localparam int IN_W = ((3*VI_W+bfsp_pkg::WEIGHT_WIDTH_DEF+7)/8)*8;
	localparam int NV_MAX = bfsp_pkg::MAX_VERTICES_DEF;
	localparam int NE_MAX = bfsp_pkg::MAX_EDGES_DEF;

	// One result beat as the block reports it.
	typedef struct {
		logic [1:0]              status;
		logic [VI_W-1:0]         vidx;
		logic signed [LEN_W-1:0] path_len;
		logic                    reach;
		logic                    last;
	} path_beat_t;

	// How a run's results are obtained: from the predictor, or typed in.
	typedef enum {CHK_MODEL, CHK_ALONE_REACHED, CHK_BAD_SOURCE, CHK_NEG_CYCLE} chk_t;
	typedef enum {ROW_LOAD, ROW_RUN, ROW_CFG} row_kind_t;

	typedef struct {
		row_kind_t kind;
		logic      reg_idx;
		int        a;
		int        b;
		int        w;
		chk_t      chk;
	} stim_row_t;

	logic              clk;
	logic              arst_n;
	logic              s_axis_tvalid;
	logic              s_axis_tready;
	// tdata: edge_from, edge_to, edge_weight, start_vertex, zero fill
	logic [IN_W-1:0]   s_axis_tdata;
	// tuser: func
	logic              s_axis_tuser;
	logic              m_axis_tvalid;
	logic              m_axis_tready;
	// tdata: status, vertex_index, path_length, reachable, zero fill
	logic [31:0]       m_axis_tdata;
	logic              m_axis_tlast;
	logic              cfg_we;
	logic              cfg_index;
	logic [bfsp_pkg::CFG_W-1:0] cfg_wdata;

	// Predictor state.
	logic [VI_W-1:0]          edge_src [NE_MAX];
	logic [VI_W-1:0]          edge_dst [NE_MAX];
	logic signed [15:0]       edge_wt [NE_MAX];
	int                       fill_count;
	longint                   best_len [NV_MAX];
	bit                       reached [NV_MAX];
	logic [bfsp_pkg::VCNT_W-1:0] vcount_reg;
	logic [bfsp_pkg::ECNT_W-1:0] ecount_reg;

	path_beat_t expected_beats[$];
	int         error_count;
	int         runs_sent, loads_sent, beats_seen, negcyc_seen, badsrc_seen;
	bit         quiet;
	int         out_stall;
	stim_row_t  directed[];

	bellman_ford_shortest_paths dut (
		.clk(clk), .arst_n(arst_n),
		.s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
		.m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata), .m_axis_tlast(m_axis_tlast),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
	);

	initial clk = 1'b0;
	always #6 clk = ~clk;

	task automatic report(input string what);
		error_count++;
		$display("[%0t] mismatch: %s", $realtime, what);
	endtask

	// Append one beat to the tail of the expectation queue.
	function automatic void queue_beat(input path_beat_t b);
		expected_beats.insert(expected_beats.size(), b);
	endfunction

	function automatic path_beat_t status_beat(input logic [1:0] st);
		path_beat_t b;
		b.status = st;
		b.vidx = '0;
		b.path_len = '0;
		b.reach = 1'b0;
		b.last = 1'b1;
		return b;
	endfunction

	// Append one edge; the store saturates when full.
	function automatic void store_edge(input logic [5:0] fr, to, input logic [15:0] w);
		if (fill_count < NE_MAX) begin
			edge_src[fill_count] = fr;
			edge_dst[fill_count] = to;
			edge_wt[fill_count] = w;
			fill_count++;
		end
	endfunction

	function automatic int active_vertices();
		if (vcount_reg == 0)
			return 1;
		return (vcount_reg > NV_MAX) ? NV_MAX : int'(vcount_reg);
	endfunction

	// Edge e can still lower its destination; cand receives the exact sum.
	function automatic bit relaxable(input int e, input int nv, output longint cand);
		int u;
		int v;
		u = edge_src[e];
		v = edge_dst[e];
		cand = 0;
		if (u >= nv || v >= nv || !reached[u])
			return 0;
		cand = best_len[u] + longint'(edge_wt[e]);
		return !reached[v] || cand < best_len[v];
	endfunction

	// Full shortest path run from one source, queueing the expected beats.
	function automatic void shortest_path_run(input int src);
		int nv;
		int ne;
		bit neg;
		longint cand;
		path_beat_t b;
		nv = active_vertices();
		ne = (ecount_reg > NE_MAX) ? NE_MAX : int'(ecount_reg);
		for (int i = 0; i < NV_MAX; i++) begin
			best_len[i] = 0;
			reached[i] = 0;
		end
		if (src >= nv) begin
			queue_beat(status_beat(bfsp_pkg::ST_BADSRC));
			return;
		end
		reached[src] = 1;
		for (int p = 1; p < nv; p++)
			for (int e = 0; e < ne; e++)
				if (relaxable(e, nv, cand)) begin
					if (cand < bfsp_pkg::DIST_MIN) cand = bfsp_pkg::DIST_MIN;
					if (cand > bfsp_pkg::DIST_MAX) cand = bfsp_pkg::DIST_MAX;
					best_len[edge_dst[e]] = cand;
					reached[edge_dst[e]] = 1;
				end
		neg = 0;
		for (int e = 0; e < ne; e++)
			if (relaxable(e, nv, cand))
				neg = 1;
		if (neg) begin
			queue_beat(status_beat(bfsp_pkg::ST_NEGCYC));
			return;
		end
		for (int i = 0; i < nv; i++) begin
			b.status = bfsp_pkg::ST_DIST;
			b.vidx = i[VI_W-1:0];
			b.path_len = reached[i] ? best_len[i][LEN_W-1:0] : '0;
			b.reach = reached[i];
			b.last = (i + 1 == nv);
			queue_beat(b);
		end
	endfunction

	// Wait until every result is in and the block has settled.
	task automatic wait_idle();
		while (expected_beats.size() != 0)
			@(posedge clk);
		repeat (8) @(posedge clk);
	endtask

	task automatic set_register(input logic idx, input int value);
		s_axis_tvalid <= 1'b0;
		wait_idle();
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_wdata <= value[bfsp_pkg::CFG_W-1:0];
		@(posedge clk);
		cfg_we <= 1'b0;
		if (idx == bfsp_pkg::CFG_VERTEX_COUNT)
			vcount_reg = value[bfsp_pkg::VCNT_W-1:0];
		else
			ecount_reg = value[bfsp_pkg::ECNT_W-1:0];
	endtask

	// Offer one beat, wait for acceptance, then update the predictor.
	task automatic send_item(input logic fn, input logic [5:0] fr, to,
		input logic [15:0] w, input logic [5:0] sv, input chk_t chk);
		logic [IN_W-1:0] d;
		int gap;
		if (!quiet && $urandom_range(0, 3) == 0) begin
			gap = $urandom_range(1, 16);
			s_axis_tvalid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		d = '0;
		d[5:0] = fr;
		d[11:6] = to;
		d[27:12] = w;
		d[33:28] = sv;
		s_axis_tvalid <= 1'b1;
		s_axis_tuser <= fn;
		s_axis_tdata <= d;
		do @(posedge clk); while (!s_axis_tready);
		if (!fn) begin
			loads_sent++;
			store_edge(fr, to, w);
		end else begin
			runs_sent++;
			case (chk)
				CHK_ALONE_REACHED: begin
					queue_beat('{bfsp_pkg::ST_DIST, '0, '0, 1'b1, 1'b1});
				end
				CHK_BAD_SOURCE: queue_beat(status_beat(bfsp_pkg::ST_BADSRC));
				CHK_NEG_CYCLE: queue_beat(status_beat(bfsp_pkg::ST_NEGCYC));
				default: shortest_path_run(sv);
			endcase
		end
	endtask

	// Result side: random stall bursts and comparison with the oldest expectation.
	initial begin
		path_beat_t got;
		path_beat_t want;
		m_axis_tready = 1'b1;
		out_stall = 0;
		forever begin
			@(posedge clk);
			if (m_axis_tvalid && m_axis_tready) begin
				beats_seen++;
				got.status = m_axis_tdata[1:0];
				got.vidx = m_axis_tdata[7:2];
				got.path_len = m_axis_tdata[29:8];
				got.reach = m_axis_tdata[30];
				got.last = m_axis_tlast;
				if (got.status == bfsp_pkg::ST_NEGCYC) negcyc_seen++;
				if (got.status == bfsp_pkg::ST_BADSRC) badsrc_seen++;
				if (expected_beats.size() == 0) begin
					report($sformatf("unexpected beat status %0d vertex %0d",
						got.status, got.vidx));
				end else begin
					want = expected_beats.pop_front();
					if (got.status !== want.status)
						report($sformatf("status %0d, want %0d", got.status, want.status));
					if (got.vidx !== want.vidx)
						report($sformatf("vertex %0d, want %0d", got.vidx, want.vidx));
					if (got.path_len !== want.path_len)
						report($sformatf("vertex %0d distance %0d, want %0d",
							want.vidx, got.path_len, want.path_len));
					if (got.reach !== want.reach)
						report($sformatf("vertex %0d reachable %0b, want %0b",
							want.vidx, got.reach, want.reach));
					if (got.last !== want.last)
						report($sformatf("vertex %0d last %0b, want %0b",
							want.vidx, got.last, want.last));
				end
			end
			if (out_stall > 0) begin
				out_stall--;
				m_axis_tready <= 1'b0;
			end else if (!quiet && $urandom_range(0, 7) == 0) begin
				out_stall = $urandom_range(0, 15);
				m_axis_tready <= 1'b0;
			end else begin
				m_axis_tready <= 1'b1;
			end
		end
	end

	// Run time limit.
	initial begin
		#300_000_000;
		$display("DONE: errors detected");
		$finish;
	end

	// Stimulus.
	initial begin
		int nv;
		int n;
		int sp;
		logic [15:0] w;
		arst_n = 1'b0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = 1'b0;
		cfg_we = 1'b0;
		cfg_index = bfsp_pkg::CFG_VERTEX_COUNT;
		cfg_wdata = '0;
		quiet = 0;
		fill_count = 0;
		vcount_reg = 1;
		ecount_reg = 0;
		for (int i = 0; i < NE_MAX; i++) begin
			edge_src[i] = '0;
			edge_dst[i] = '0;
			edge_wt[i] = '0;
		end
		directed = '{
			'{ROW_CFG, bfsp_pkg::CFG_VERTEX_COUNT, 0, 0, 0, CHK_MODEL},
			'{ROW_RUN, 1'b0, 0, 0, 0, CHK_ALONE_REACHED},
			'{ROW_RUN, 1'b0, 63, 0, 0, CHK_BAD_SOURCE},
			'{ROW_LOAD, 1'b0, 0, 1, 32767, CHK_MODEL},
			'{ROW_LOAD, 1'b0, 1, 2, -32768, CHK_MODEL},
			'{ROW_LOAD, 1'b0, 2, 63, -1, CHK_MODEL},
			'{ROW_LOAD, 1'b0, 63, 0, 5, CHK_MODEL},
			'{ROW_LOAD, 1'b0, 3, 3, 0, CHK_MODEL},
			'{ROW_CFG, bfsp_pkg::CFG_VERTEX_COUNT, 64, 0, 0, CHK_MODEL},
			'{ROW_CFG, bfsp_pkg::CFG_EDGE_COUNT, 5, 0, 0, CHK_MODEL},
			'{ROW_RUN, 1'b0, 0, 0, 0, CHK_MODEL},
			'{ROW_RUN, 1'b0, 63, 0, 0, CHK_MODEL},
			'{ROW_LOAD, 1'b0, 4, 5, -3, CHK_MODEL},
			'{ROW_LOAD, 1'b0, 5, 4, 1, CHK_MODEL},
			'{ROW_CFG, bfsp_pkg::CFG_EDGE_COUNT, 7, 0, 0, CHK_MODEL},
			'{ROW_RUN, 1'b0, 4, 0, 0, CHK_NEG_CYCLE},
			'{ROW_RUN, 1'b0, 0, 0, 0, CHK_MODEL},
			'{ROW_CFG, bfsp_pkg::CFG_VERTEX_COUNT, 3, 0, 0, CHK_MODEL},
			'{ROW_RUN, 1'b0, 2, 0, 0, CHK_MODEL},
			'{ROW_RUN, 1'b0, 3, 0, 0, CHK_BAD_SOURCE},
			'{ROW_CFG, bfsp_pkg::CFG_VERTEX_COUNT, 127, 0, 0, CHK_MODEL},
			'{ROW_RUN, 1'b0, 63, 0, 0, CHK_MODEL}
		};
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table: extremes, out-of-range edges and sources, a negative cycle.
		foreach (directed[i]) begin
			case (directed[i].kind)
				ROW_CFG: set_register(directed[i].reg_idx, directed[i].a);
				ROW_LOAD: send_item(1'b0, directed[i].a[5:0], directed[i].b[5:0],
					directed[i].w[15:0], 6'($urandom), CHK_MODEL);
				default: send_item(1'b1, 6'($urandom), 6'($urandom), 16'($urandom),
					directed[i].a[5:0], directed[i].chk);
			endcase
		end

		// Random phases: new settings, then edge loads mixed with runs.
		for (int ph = 0; ph < 20; ph++) begin
			quiet = (ph >= 16);
			case ($urandom_range(0, 9))
				0: set_register(bfsp_pkg::CFG_VERTEX_COUNT, 0);
				1: set_register(bfsp_pkg::CFG_VERTEX_COUNT, 64);
				2: set_register(bfsp_pkg::CFG_VERTEX_COUNT, 127);
				default: set_register(bfsp_pkg::CFG_VERTEX_COUNT, $urandom_range(1, 16));
			endcase
			if (fill_count == NE_MAX && $urandom_range(0, 2) == 0)
				set_register(bfsp_pkg::CFG_EDGE_COUNT, $urandom_range(NE_MAX, 511));
			else if ($urandom_range(0, 5) == 0)
				set_register(bfsp_pkg::CFG_EDGE_COUNT, fill_count);
			else
				set_register(bfsp_pkg::CFG_EDGE_COUNT, $urandom_range(0, fill_count));
			nv = active_vertices();
			n = $urandom_range(12, 18);
			for (int k = 0; k < n; k++) begin
				if (ph == 3 && k == n / 2) begin
					// Hold the sender off until all results have drained.
					s_axis_tvalid <= 1'b0;
					wait_idle();
				end
				if ($urandom_range(0, 3) == 0) begin
					send_item(1'b1, 6'($urandom), 6'($urandom), 16'($urandom),
						($urandom_range(0, 4) == 0) ? 6'($urandom) :
						6'($urandom_range(0, nv - 1)), CHK_MODEL);
				end else begin
					sp = ($urandom_range(0, 4) == 0) ? 63 : 15;
					if ($urandom_range(0, 3) == 0)
						w = 16'($urandom);
					else
						w = 16'($urandom_range(0, 300) - 40);
					send_item(1'b0, 6'($urandom_range(0, sp)), 6'($urandom_range(0, sp)),
						w, 6'($urandom), CHK_MODEL);
				end
			end
		end
		s_axis_tvalid <= 1'b0;
		wait_idle();
		repeat (50) @(posedge clk);

		$display("Covered %0d runs and %0d edge loads (%0d stored), %0d result beats.",
			runs_sent, loads_sent, fill_count, beats_seen);
		$display("Status beats seen: %0d negative cycle, %0d bad source.",
			negcyc_seen, badsrc_seen);
		if (error_count == 0)
			$display("DONE: 0 errors");
		else
			$display("DONE: errors detected");
		$finish;
	end
endmodule

// File: sim.f
rtl/bfsp_pkg.sv
rtl/bfsp_ram.sv
rtl/bfsp_datapath.sv
rtl/bfsp_ctrl.sv
rtl/bellman_ford_shortest_paths.sv
tb/sv/testbench.sv
